>>> rtl/lskt_pkg.sv
`default_nettype none

package lskt_pkg;

	localparam int unsigned KEY_W  = 32;
	localparam int unsigned SLOT_W = 6;
	localparam int unsigned FILL_W = 7;

	typedef enum logic [1:0] {
		MODE_FIND   = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_READ   = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		STAT_HIT       = 3'd0,
		STAT_MISS      = 3'd1,
		STAT_NEW       = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_BAD_INDEX = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_EXEC  = 3'd1,
		ST_SCAN  = 3'd2,
		ST_RDATA = 3'd3,
		ST_DONE  = 3'd4
	} state_t;

	typedef struct packed {
		mode_t              mode;
		logic [KEY_W-1:0]   key;
		logic [SLOT_W-1:0]  slot_index;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [SLOT_W-1:0]  slot;
		logic [KEY_W-1:0]   key_out;
		logic [FILL_W-1:0]  fill_count;
	} rsp_t;

endpackage

`default_nettype wire

>>> rtl/lskt_req_if.sv
`default_nettype none

interface lskt_req_if import lskt_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/lskt_rsp_if.sv
`default_nettype none

interface lskt_rsp_if import lskt_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/lskt_ram.sv
`default_nettype none

// single write port, single read port, registered read data
module lskt_ram import lskt_pkg::*; #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [KEY_W-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [KEY_W-1:0] rd_data
);

	logic [KEY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/linear_search_key_table.sv
// Path from request to response: find and insert pass exec, scan and done; a read passes
// exec, read data and done; a bad index or a clear passes exec and done.
// Throughput: one request at a time, one stored key read per cycle while scanning; the next
// request is taken on return to idle, which done enters once the response register is free.
// Reset (arst_n, async, active low) empties the table and drops any pending response;
// key RAM contents are not cleared, only slots below the fill count are ever read.
`default_nettype none

module linear_search_key_table import lskt_pkg::*; #(
	parameter int unsigned CAPACITY = 64
) (
	input wire logic  clk,
	input wire logic  arst_n,
	lskt_req_if.sink  req,
	lskt_rsp_if.source rsp
);

	localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	// count/pointer width, able to hold CAPACITY itself
	localparam int unsigned CW    = $clog2(CAPACITY + 1);
	// common width for comparing the 6-bit slot index with the count
	localparam int unsigned CMP_W = (CW > SLOT_W) ? CW : SLOT_W;

	state_t           state_q, state_d;
	req_t             req_q;
	logic [CW-1:0]    count_q, count_d;
	logic [CW-1:0]    ptr_q, ptr_d;       // next slot to read in a scan
	logic             issued_s1, issued_d; // a scan read is in flight
	logic [AW-1:0]    addr_s1, addr_d;     // slot of the read in flight
	rsp_t             res_q, res_d;        // result under construction
	logic             rsp_valid_q;
	rsp_t             rsp_data_q;

	logic             rd_en, wr_en;
	logic [AW-1:0]    rd_addr, wr_addr;
	logic [KEY_W-1:0] rd_data;

	logic             scan_more, hit, scan_done, idx_ok, rsp_free, full;

	lskt_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (req_q.key),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// scan status: the compare stage sees the key read in the previous cycle
	assign scan_more = ptr_q < count_q;
	assign hit       = issued_s1 && (rd_data == req_q.key);
	assign scan_done = hit || (!issued_s1 && !scan_more);
	assign idx_ok    = CMP_W'(req_q.slot_index) < CMP_W'(count_q);
	assign full      = count_q == CW'(CAPACITY);
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	assign req.ready   = state_q == ST_IDLE;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_data_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				unique case (req_q.mode) inside
					MODE_FIND, MODE_INSERT: state_d = ST_SCAN;
					MODE_READ:              state_d = idx_ok ? ST_RDATA : ST_DONE;
					MODE_CLEAR:             state_d = ST_DONE;
				endcase
			end
			ST_SCAN: begin
				if (scan_done) state_d = ST_DONE;
			end
			ST_RDATA: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (rsp_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath controls
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = AW'(ptr_q);
		wr_en    = 1'b0;
		wr_addr  = AW'(count_q);
		count_d  = count_q;
		ptr_d    = ptr_q;
		issued_d = 1'b0;
		addr_d   = addr_s1;
		res_d    = res_q;
		unique case (state_q)
			ST_EXEC: begin
				res_d = '{status: STAT_HIT, slot: '0, key_out: '0, fill_count: '0};
				ptr_d = '0;
				unique case (req_q.mode) inside
					MODE_FIND, MODE_INSERT: begin
					end
					MODE_READ: begin
						if (idx_ok) begin
							rd_en      = 1'b1;
							rd_addr    = AW'(req_q.slot_index);
							res_d.slot = req_q.slot_index;
						end else begin
							res_d.status  = STAT_BAD_INDEX;
							res_d.key_out = '1;
						end
					end
					MODE_CLEAR: begin
						count_d = '0;
					end
				endcase
			end
			ST_SCAN: begin
				// overlap: issue the next read while comparing the previous one
				if (scan_more && !hit) begin
					rd_en    = 1'b1;
					ptr_d    = ptr_q + CW'(1);
					issued_d = 1'b1;
					addr_d   = AW'(ptr_q);
				end
				if (hit) begin
					res_d.slot = SLOT_W'(addr_s1);
				end else if (scan_done) begin
					if (req_q.mode == MODE_INSERT) begin
						if (full) begin
							res_d.status = STAT_FULL;
						end else begin
							// append at the fill count
							wr_en        = 1'b1;
							res_d.status = STAT_NEW;
							res_d.slot   = SLOT_W'(count_q);
							count_d      = count_q + CW'(1);
						end
					end else begin
						res_d.status = STAT_MISS;
					end
				end
			end
			ST_RDATA: begin
				res_d.key_out = rd_data;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			issued_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			issued_s1 <= issued_d;
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_q <= req.payload;
		end
		ptr_q   <= ptr_d;
		addr_s1 <= addr_d;
		res_q   <= res_d;
		if (state_q == ST_DONE && rsp_free) begin
			rsp_data_q <= '{status: res_q.status, slot: res_q.slot,
				key_out: res_q.key_out, fill_count: FILL_W'(count_q)};
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_SCAN && req_q.mode == MODE_INSERT && !full))
		else $error("key write outside an appending insert");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> ptr_q <= count_q)
		else $error("scan pointer past fill count");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && rsp_free) |=> (rsp_valid_q && state_q == ST_IDLE))
		else $error("finished request not presented");

	a_single_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		issued_s1 |-> state_q == ST_SCAN)
		else $error("scan read in flight outside scan");
`endif

endmodule

`default_nettype wire
